[sv/dldp_pkg.sv]
// Shared types, constants and the per-byte line update for the dollar decimal line parser.
package dldp_pkg;

  localparam int INT_DIGITS  = 7;
  localparam int FRAC_DIGITS = 6;
  localparam int LINE_LEN    = INT_DIGITS + FRAC_DIGITS + 2;
  localparam int POS_W       = 5;
  localparam int INT_W       = 24;
  localparam int FRAC_W      = 20;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              nonempty;
    logic              skip;
    logic              bad;
    logic              cr;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
  } line_state_t;

  typedef struct packed {
    logic              emit;
    logic              status;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_part;
  } line_result_t;

  // One content byte of a line: position check, format check, times-ten accumulate.
  function automatic line_state_t take_content(line_state_t s, logic [7:0] c);
    line_state_t n;
    logic        digit;
    n        = s;
    digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    n.nonempty = 1'b1;
    if (!s.skip) begin
      if (s.pos >= POS_W'(LINE_LEN)) begin
        n.bad = 1'b1;
      end else begin
        n.pos = s.pos + POS_W'(1);
        if (s.pos == '0) begin
          if (c != CH_DOLLAR) n.skip = 1'b1;
        end else if (s.pos <= POS_W'(INT_DIGITS)) begin
          if (digit)
            n.int_acc = (s.int_acc << 3) + (s.int_acc << 1) + {{(INT_W-4){1'b0}}, c[3:0]};
          else
            n.bad = 1'b1;
        end else if (s.pos == POS_W'(INT_DIGITS + 1)) begin
          if (c != CH_DOT) n.bad = 1'b1;
        end else begin
          if (digit)
            n.frac_acc = (s.frac_acc << 3) + (s.frac_acc << 1)
                       + {{(FRAC_W-4){1'b0}}, c[3:0]};
          else
            n.bad = 1'b1;
        end
      end
    end
    return n;
  endfunction

endpackage

[sv/dollar_decimal_line_parser.sv]
// Top level of the dollar decimal line parser: input word register, line decode, result register.
// An accepted word is decoded from the input word register; its result is registered before out_*.
// Throughput: one byte per cycle; the line state register in dldp_core closes its loop each cycle.
// Stalls: input stage and result register advance together, so in_stall rises only when both
//   hold a word and out_stall is high.
// Reset: synchronous active-low rst_n empties both stages and clears the line state.
module dollar_decimal_line_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [dldp_pkg::INT_W-1:0]    out_integer_part,
  output logic [dldp_pkg::FRAC_W-1:0]   out_fraction_micro
);

  // input word register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;

  // result register
  logic                        out_vld_r;
  logic                        out_status_r;
  logic [dldp_pkg::INT_W-1:0]  out_int_r;
  logic [dldp_pkg::FRAC_W-1:0] out_frac_r;

  logic                   advance;
  logic                   step;
  dldp_pkg::line_result_t res;

  // the pipeline moves whenever the result register is free or being drained
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !advance;
  assign step     = s1_vld_r && advance;

  dldp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= step && res.emit;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
    if (step && res.emit) begin
      out_status_r <= res.status;
      out_int_r    <= res.int_part;
      out_frac_r   <= res.frac_part;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_integer_part   = out_int_r;
  assign out_fraction_micro = out_frac_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r == dldp_pkg::STATUS_ERR) |-> (out_int_r == '0 && out_frac_r == '0))
    else $error("error word carries a nonzero value");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a held result");

  a_result_from_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && $past(1'b1) && out_vld_r && !$past(out_vld_r && out_stall))
      |-> $past(s1_vld_r && s1_byte_r == dldp_pkg::CH_LF))
    else $error("result word not caused by an LF");

endmodule

[sv/dldp_core.sv]
// Line state register and per-byte decode of the dollar decimal line parser.
module dldp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output dldp_pkg::line_result_t res
);

  dldp_pkg::line_state_t st_r, st_nxt, st_mid;

  always_comb begin
    st_mid = st_r;
    st_nxt = st_r;
    res    = '0;
    if (rx_byte == dldp_pkg::CH_LF) begin
      // LF closes the line; a held CR is simply dropped with it
      res.emit = st_r.nonempty && !st_r.skip;
      if (st_r.bad || st_r.pos != dldp_pkg::POS_W'(dldp_pkg::LINE_LEN)) begin
        res.status = dldp_pkg::STATUS_ERR;
      end else begin
        res.status    = dldp_pkg::STATUS_OK;
        res.int_part  = st_r.int_acc;
        res.frac_part = st_r.frac_acc;
      end
      st_nxt = '0;
    end else begin
      // a held CR not followed by LF counts as line content
      if (st_r.cr) begin
        st_mid    = dldp_pkg::take_content(st_r, dldp_pkg::CH_CR);
        st_mid.cr = 1'b0;
      end
      if (rx_byte == dldp_pkg::CH_CR) begin
        st_nxt    = st_mid;
        st_nxt.cr = 1'b1;
      end else begin
        st_nxt = dldp_pkg::take_content(st_mid, rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos <= dldp_pkg::POS_W'(dldp_pkg::LINE_LEN))
    else $error("line position past full format length");

  a_flags_need_content: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.skip || st_r.bad || st_r.pos != '0) |-> st_r.nonempty)
    else $error("line flags set on an empty line");

  a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && rx_byte == dldp_pkg::CH_LF) |=> (st_r == '0))
    else $error("line state not cleared after LF");

endmodule
